// ===== src/fms_pkg.sv =====
`default_nettype none
package fms_pkg;

  typedef enum logic [3:0] {
    MODE_FLYING  = 4'b0001,
    MODE_LANDING = 4'b0010,
    MODE_LANDED  = 4'b0100,
    MODE_STARTUP = 4'b1000
  } mode_e;

  localparam logic [1:0] STATUS_FLYING  = 2'd0;
  localparam logic [1:0] STATUS_LANDING = 2'd1;
  localparam logic [1:0] STATUS_LANDED  = 2'd2;
  localparam logic [1:0] STATUS_STARTUP = 2'd3;

  localparam logic [1:0] REG_LANDED_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_ALTITUDE_STEP    = 2'd1;
  localparam logic [1:0] REG_YAW_STEP         = 2'd2;
  localparam logic [1:0] REG_ALTITUDE_LIMIT   = 2'd3;

  localparam logic [6:0] LANDED_THRESHOLD_RST = 7'd5;
  localparam logic [5:0] ALTITUDE_STEP_RST    = 6'd10;
  localparam logic [7:0] YAW_STEP_RST         = 8'd15;
  localparam logic [6:0] ALTITUDE_LIMIT_RST   = 7'd100;

  localparam int unsigned CFG_DATA_W = 8;

  typedef struct packed {
    logic [6:0] landed_threshold;
    logic [5:0] altitude_step;
    logic [7:0] yaw_step;
    logic [6:0] altitude_limit;
  } cfg_t;

  typedef struct packed {
    logic              operation;
    logic              mode_switch_up;
    logic              up_pushed;
    logic              down_pushed;
    logic              left_pushed;
    logic              right_pushed;
    logic              yaw_ref_found;
    logic signed [7:0] altitude_percent;
  } item_t;

  typedef struct packed {
    logic [1:0]         flight_status;
    logic [6:0]         altitude_setpoint;
    logic signed [15:0] yaw_setpoint;
    logic               start_motors;
    logic               stop_motors;
    logic               transition_busy;
    logic               motors_active;
    logic               tail_search_mode;
  } result_t;

  function automatic logic [1:0] mode_code(mode_e m);
    logic [1:0] c;
    unique case (m)
      MODE_FLYING:  c = STATUS_FLYING;
      MODE_LANDING: c = STATUS_LANDING;
      MODE_LANDED:  c = STATUS_LANDED;
      MODE_STARTUP: c = STATUS_STARTUP;
      default:      c = STATUS_LANDED;
    endcase
    return c;
  endfunction

  // saturating yaw step, sub selects subtraction
  function automatic logic signed [15:0] yaw_add(logic signed [15:0] yaw, logic [7:0] step,
                                                 logic sub);
    logic signed [16:0] s;
    logic signed [16:0] d;
    logic signed [15:0] r;
    d = $signed({9'd0, step});
    s = sub ? (17'(yaw) - d) : (17'(yaw) + d);
    if (s > 17'sd32767) begin
      r = 16'sh7FFF;
    end else if (s < -17'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = s[15:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/flight_mode_sequencer.sv =====
// Flight mode sequencer.
// Pipeline: input register, then the combinational core, then the result register.
// Throughput: one item per cycle unless out_stall_i holds a valid result;
// the mode and setpoint update is a single combinational pass.
// Reset (rst_ni low, async): mode landed, setpoints zero, config registers to defaults,
// both pipeline registers empty.
`default_nettype none
module flight_mode_sequencer import fms_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [1:0]            cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  operation_i,
  input  wire logic                  mode_switch_up_i,
  input  wire logic                  up_pushed_i,
  input  wire logic                  down_pushed_i,
  input  wire logic                  left_pushed_i,
  input  wire logic                  right_pushed_i,
  input  wire logic                  yaw_ref_found_i,
  input  wire logic signed [7:0]     altitude_percent_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [1:0]                 flight_status_o,
  output logic [6:0]                 altitude_setpoint_o,
  output logic signed [15:0]         yaw_setpoint_o,
  output logic                       start_motors_o,
  output logic                       stop_motors_o,
  output logic                       transition_busy_o,
  output logic                       motors_active_o,
  output logic                       tail_search_mode_o
);

  cfg_t    cfg;
  item_t   item_in, item_q;
  result_t res_d, res_q;
  logic    item_valid;
  logic    advance;
  logic    fire;

  always_comb begin
    item_in.operation        = operation_i;
    item_in.mode_switch_up   = mode_switch_up_i;
    item_in.up_pushed        = up_pushed_i;
    item_in.down_pushed      = down_pushed_i;
    item_in.left_pushed      = left_pushed_i;
    item_in.right_pushed     = right_pushed_i;
    item_in.yaw_ref_found    = yaw_ref_found_i;
    item_in.altitude_percent = altitude_percent_i;
  end

  assign fire = item_valid && advance;

  fms_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  fms_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (item_in),
    .advance_i  (advance),
    .valid_o    (item_valid),
    .item_o     (item_q)
  );

  fms_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .fire_i (fire),
    .item_i (item_q),
    .res_o  (res_d)
  );

  fms_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .res_i       (res_d),
    .out_stall_i (out_stall_i),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .res_o       (res_q)
  );

  assign flight_status_o     = res_q.flight_status;
  assign altitude_setpoint_o = res_q.altitude_setpoint;
  assign yaw_setpoint_o      = res_q.yaw_setpoint;
  assign start_motors_o      = res_q.start_motors;
  assign stop_motors_o       = res_q.stop_motors;
  assign transition_busy_o   = res_q.transition_busy;
  assign motors_active_o     = res_q.motors_active;
  assign tail_search_mode_o  = res_q.tail_search_mode;

endmodule
`default_nettype wire

// ===== src/fms_cfg.sv =====
`default_nettype none
module fms_cfg import fms_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [1:0]            cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.landed_threshold <= LANDED_THRESHOLD_RST;
      cfg_q.altitude_step    <= ALTITUDE_STEP_RST;
      cfg_q.yaw_step         <= YAW_STEP_RST;
      cfg_q.altitude_limit   <= ALTITUDE_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_LANDED_THRESHOLD: cfg_q.landed_threshold <= cfg_wdata_i[6:0];
        REG_ALTITUDE_STEP:    cfg_q.altitude_step    <= cfg_wdata_i[5:0];
        REG_YAW_STEP:         cfg_q.yaw_step         <= cfg_wdata_i[7:0];
        REG_ALTITUDE_LIMIT:   cfg_q.altitude_limit   <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== src/fms_in_reg.sv =====
`default_nettype none
module fms_in_reg import fms_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_stall_o,
  input  wire item_t item_i,
  input  wire logic  advance_i,
  output logic       valid_o,
  output item_t      item_o
);

  logic  valid_q;
  item_t item_q;
  logic  load;

  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule
`default_nettype wire

// ===== src/fms_core.sv =====
`default_nettype none
module fms_core import fms_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire cfg_t    cfg_i,
  input  wire logic    fire_i,
  input  wire item_t   item_i,
  output result_t      res_o
);

  mode_e              mode_q, mode_d;
  logic               busy_q, busy_d;
  logic               ref_held_q, ref_held_d;
  logic               land_seen_q, land_seen_d;
  logic [6:0]         tgt_alt_q, tgt_alt_d;
  logic signed [15:0] tgt_yaw_q, tgt_yaw_d;
  logic               start, stop;
  logic               below;

  assign below = $signed(item_i.altitude_percent) < $signed({1'b0, cfg_i.landed_threshold});

  always_comb begin
    mode_d      = mode_q;
    busy_d      = busy_q;
    ref_held_d  = ref_held_q;
    land_seen_d = land_seen_q;
    tgt_alt_d   = tgt_alt_q;
    tgt_yaw_d   = tgt_yaw_q;
    start       = 1'b0;
    stop        = 1'b0;
    if (!item_i.operation) begin
      if (item_i.mode_switch_up) begin
        if (!busy_d && (mode_d == MODE_LANDED || mode_d == MODE_LANDING) && land_seen_d) begin
          mode_d = MODE_STARTUP;
        end
      end else begin
        land_seen_d = 1'b1;
        if ((mode_d == MODE_FLYING || mode_d == MODE_STARTUP) && !busy_d) begin
          mode_d = MODE_LANDING;
        end
      end
      if (item_i.up_pushed && ({1'b0, cfg_i.altitude_step} <= cfg_i.altitude_limit)
          && (tgt_alt_d <= cfg_i.altitude_limit - {1'b0, cfg_i.altitude_step})) begin
        tgt_alt_d = tgt_alt_d + {1'b0, cfg_i.altitude_step};
      end
      if (item_i.down_pushed && (tgt_alt_d >= {1'b0, cfg_i.altitude_step})) begin
        tgt_alt_d = tgt_alt_d - {1'b0, cfg_i.altitude_step};
      end
      if (item_i.left_pushed) begin
        tgt_yaw_d = yaw_add(tgt_yaw_d, cfg_i.yaw_step, 1'b1);
      end
      if (item_i.right_pushed) begin
        tgt_yaw_d = yaw_add(tgt_yaw_d, cfg_i.yaw_step, 1'b0);
      end
    end else begin
      if (mode_d == MODE_STARTUP && !busy_d) begin
        start  = 1'b1;
        busy_d = 1'b1;
      end
      if (mode_d == MODE_STARTUP && busy_d && !ref_held_d && item_i.yaw_ref_found) begin
        ref_held_d = 1'b1;
        tgt_yaw_d  = '0;
      end
      if (mode_d == MODE_STARTUP && busy_d && ref_held_d) begin
        busy_d = 1'b0;
        mode_d = MODE_FLYING;
      end
      if (mode_d == MODE_LANDING && !busy_d) begin
        tgt_alt_d = '0;
        tgt_yaw_d = '0;
        busy_d    = 1'b1;
      end
      if (mode_d == MODE_LANDING && busy_d && below) begin
        stop   = 1'b1;
        mode_d = MODE_LANDED;
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_LANDED;
      busy_q      <= 1'b0;
      ref_held_q  <= 1'b0;
      land_seen_q <= 1'b0;
      tgt_alt_q   <= '0;
      tgt_yaw_q   <= '0;
    end else if (fire_i) begin
      mode_q      <= mode_d;
      busy_q      <= busy_d;
      ref_held_q  <= ref_held_d;
      land_seen_q <= land_seen_d;
      tgt_alt_q   <= tgt_alt_d;
      tgt_yaw_q   <= tgt_yaw_d;
    end
  end

  always_comb begin
    res_o.flight_status     = mode_code(mode_d);
    res_o.altitude_setpoint = tgt_alt_d;
    res_o.yaw_setpoint      = tgt_yaw_d;
    res_o.start_motors      = start;
    res_o.stop_motors       = stop;
    res_o.transition_busy   = busy_d;
    res_o.motors_active     = (mode_d != MODE_LANDED);
    res_o.tail_search_mode  = (mode_d == MODE_STARTUP);
  end

endmodule
`default_nettype wire

// ===== src/fms_out_reg.sv =====
`default_nettype none
module fms_out_reg import fms_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    fire_i,
  input  wire result_t res_i,
  input  wire logic    out_stall_i,
  output logic         advance_o,
  output logic         out_valid_o,
  output result_t      res_o
);

  logic    valid_q;
  result_t res_q;

  assign advance_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (fire_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

// ===== src/fms_checker.sv =====
`default_nettype none
module fms_checker import fms_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  flight_status_o,
  input wire logic        start_motors_o,
  input wire logic        stop_motors_o,
  input wire logic        transition_busy_o,
  input wire logic        motors_active_o,
  input wire logic        tail_search_mode_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(flight_status_o))
    else $error("result dropped or changed under stall");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (motors_active_o == (flight_status_o != STATUS_LANDED))
                 && (tail_search_mode_o == (flight_status_o == STATUS_STARTUP)))
    else $error("mode flags disagree with flight status");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && start_motors_o |-> !stop_motors_o
      && (flight_status_o == STATUS_STARTUP || flight_status_o == STATUS_FLYING))
    else $error("motor start outside startup");

  a_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stop_motors_o |-> flight_status_o == STATUS_LANDED && !transition_busy_o)
    else $error("motor stop without landing completion");

endmodule

bind flight_mode_sequencer fms_checker u_fms_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .flight_status_o    (flight_status_o),
  .start_motors_o     (start_motors_o),
  .stop_motors_o      (stop_motors_o),
  .transition_busy_o  (transition_busy_o),
  .motors_active_o    (motors_active_o),
  .tail_search_mode_o (tail_search_mode_o)
);
`default_nettype wire
